@@ design/assembly_tokenizer_macros.svh @@
// ----------------------------------------------------------------------------
// assembly_tokenizer_macros.svh
// Assertion macros for the tokenizer; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_TOKENIZER_MACROS_SVH
`define ASSEMBLY_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, disabled in reset
`define AT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");
// next-cycle implication
`define AT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define AT_ASSERT_IMP(lbl, ante, cons)
`define AT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/at_pkg.sv @@
// ----------------------------------------------------------------------------
// at_pkg
// Shared types and token kind codes for the assembly tokenizer.
// ----------------------------------------------------------------------------
package at_pkg;

    localparam int KIND_W = 4;
    localparam int CHR_W  = 8;
    localparam int VAL_W  = 31;

    localparam logic [KIND_W-1:0] KIND_TEXT        = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT_END   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LABEL_END   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_STRING_END  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_INTEGER     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LPAREN      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RPAREN      = 4'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACE      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACE      = 4'd8;
    localparam logic [KIND_W-1:0] KIND_ILLEGAL     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_EOF         = 4'd10;
    localparam logic [KIND_W-1:0] KIND_OPEN_STRING = 4'd11;

    // token queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHR_W-1:0]  chr;
    } tok_t;

    // everything one character produces: one or two tokens
    typedef struct packed {
        logic             two;
        tok_t             t0;
        tok_t             t1;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

@@ design/assembly_tokenizer.sv @@
// ----------------------------------------------------------------------------
// assembly_tokenizer
// Character-at-a-time lexer for a small assembly language.
// ----------------------------------------------------------------------------
// Input stream s_*: one source character per item, tdata[7:0]; zero ends input.
// Output stream m_*: one token per item. tuser carries the token kind, tdata
// the character (text and illegal tokens) and the saturated integer value,
// tlast marks the final token caused by one input character.
// A character is taken every cycle while the four-entry token queue has room.
// From input to first token, the front end writes the queue in the accept cycle and
// the output register loads from the queue head once it is free or being taken.
// A character giving two tokens shows the first, then the second from a pending
// register, holding the queue; others run at one per cycle while m_tready is high.
// Integers are emitted on the first non-digit, so they appear one character late.
// When the receiver stalls, the output register holds its token, the queue
// fills and s_tready drops once four entries wait.
// Reset (rst_n low, asynchronous) returns the lexer to idle with a clear
// accumulator and empties the queue and the output register.
// ----------------------------------------------------------------------------
`include "assembly_tokenizer_macros.svh"

module assembly_tokenizer #(
    parameter int INT_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] text_char, [38:8] int_value, [39] zero
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast
);
    import at_pkg::*;

    logic             q_full, q_push, q_pop, q_valid;
    entry_t           q_in, q_head;
    logic [CHR_W-1:0] out_chr;
    logic [VAL_W-1:0] out_value;
    logic             pend;

    at_front #(
        .INT_BITS (INT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ch_valid (s_tvalid),
        .ch_ready (s_tready),
        .ch       (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    at_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    at_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_chr    (out_chr),
        .out_value  (out_value),
        .out_last   (m_tlast),
        .pend       (pend)
    );

    assign m_tdata = {1'b0, out_value, out_chr};

    // second token of a pair only waits behind a shown first token
    `AT_ASSERT_IMP(a_pend_behind_out, pend, m_tvalid)
    // the second token of a pair follows straight after the first is taken
    `AT_ASSERT_NXT(a_pair_back_to_back, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)
    // only text and illegal tokens carry a character
    `AT_ASSERT_IMP(a_chr_zero, m_tvalid && (m_tuser != KIND_TEXT) && (m_tuser != KIND_ILLEGAL), m_tdata[7:0] == 8'h00)
    // only integer tokens carry a value
    `AT_ASSERT_IMP(a_value_zero, m_tvalid && (m_tuser != KIND_INTEGER), m_tdata[38:8] == 31'd0)

endmodule

@@ design/at_front.sv @@
// ----------------------------------------------------------------------------
// at_front
// Lexer front end: takes characters, tracks mode and accumulator, queues tokens.
// ----------------------------------------------------------------------------
module at_front #(
    parameter int INT_BITS = 31
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ch_valid,
    output logic            ch_ready,
    input  logic [7:0]      ch,
    input  logic            q_full,
    output logic            q_push,
    output at_pkg::entry_t  q_entry
);
    import at_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_INT     = 3'd2;
    localparam logic [2:0] M_IDENT   = 3'd3;
    localparam logic [2:0] M_LABEL   = 3'd4;
    localparam logic [2:0] M_STRING  = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5a;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    logic [2:0]          mode_reg, mode_next;
    logic [INT_BITS-1:0] acc_reg, acc_next;

    logic                is_num, is_word;
    logic [INT_BITS+3:0] acc_x10;
    logic                acc_sat;
    logic [63:0]         acc_wide;
    logic [VAL_W-1:0]    acc_val;
    logic [INT_BITS-1:0] digit_val;

    logic                idle_emit, idle_digit;
    logic [KIND_W-1:0]   idle_kind;
    logic [CHR_W-1:0]    idle_chr;
    logic [2:0]          idle_mode;

    logic                emit;
    entry_t              ent;
    logic                accept;

    assign is_num    = ch inside {[CH_0:CH_9]};
    assign is_word   = ch inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_BANG, CH_QMARK, CH_DASH};
    assign digit_val = INT_BITS'(ch[3:0]);

    // a*10 + d; any set bit from INT_BITS upward means saturation
    assign acc_x10 = (INT_BITS+4)'({acc_reg, 3'b000}) + (INT_BITS+4)'({acc_reg, 1'b0})
                   + (INT_BITS+4)'(ch[3:0]);
    assign acc_sat  = |acc_x10[INT_BITS+3:INT_BITS];
    assign acc_wide = 64'(acc_reg);
    assign acc_val  = acc_wide[VAL_W-1:0];

    // what the character does when seen in idle mode
    always_comb
    begin
        idle_emit  = 1'b0;
        idle_kind  = KIND_TEXT;
        idle_chr   = '0;
        idle_mode  = M_IDLE;
        idle_digit = 1'b0;
        case (ch)
            CH_SPACE, CH_TAB, CH_LF, CH_CR:
            begin
                idle_mode = M_IDLE;
            end
            CH_SEMI:   idle_mode = M_COMMENT;
            CH_QUOTE:  idle_mode = M_STRING;
            CH_PCT:    idle_mode = M_LABEL;
            CH_NUL:
            begin
                idle_emit = 1'b1;
                idle_kind = KIND_EOF;
            end
            CH_LBRACE:
            begin
                idle_emit = 1'b1;
                idle_kind = KIND_LBRACE;
            end
            CH_RBRACE:
            begin
                idle_emit = 1'b1;
                idle_kind = KIND_RBRACE;
            end
            CH_LPAREN:
            begin
                idle_emit = 1'b1;
                idle_kind = KIND_LPAREN;
            end
            CH_RPAREN:
            begin
                idle_emit = 1'b1;
                idle_kind = KIND_RPAREN;
            end
            default:
            begin
                if (is_num)
                begin
                    idle_mode  = M_INT;
                    idle_digit = 1'b1;
                end
                else if (is_word)
                begin
                    idle_mode = M_IDENT;
                    idle_emit = 1'b1;
                    idle_kind = KIND_TEXT;
                    idle_chr  = ch;
                end
                else
                begin
                    idle_emit = 1'b1;
                    idle_kind = KIND_ILLEGAL;
                    idle_chr  = ch;
                end
            end
        endcase
    end

    always_comb
    begin
        emit      = 1'b0;
        ent       = '0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        case (mode_reg)
            M_COMMENT:
            begin
                if (ch == CH_LF)
                begin
                    mode_next = M_IDLE;
                end
                else if (ch == CH_NUL)
                begin
                    mode_next   = M_IDLE;
                    acc_next    = '0;
                    emit        = 1'b1;
                    ent.t0.kind = KIND_EOF;
                end
            end
            M_INT:
            begin
                if (is_num)
                begin
                    acc_next = acc_sat ? '1 : acc_x10[INT_BITS-1:0];
                end
                else
                begin
                    emit        = 1'b1;
                    ent.t0.kind = KIND_INTEGER;
                    ent.value   = acc_val;
                    ent.two     = idle_emit;
                    ent.t1      = '{kind: idle_kind, chr: idle_chr};
                    mode_next   = idle_mode;
                    acc_next    = '0;
                end
            end
            M_IDENT, M_LABEL:
            begin
                emit = 1'b1;
                if (is_word)
                begin
                    ent.t0 = '{kind: KIND_TEXT, chr: ch};
                end
                else
                begin
                    ent.t0.kind = (mode_reg == M_IDENT) ? KIND_IDENT_END : KIND_LABEL_END;
                    ent.two     = idle_emit;
                    ent.t1      = '{kind: idle_kind, chr: idle_chr};
                    mode_next   = idle_mode;
                    acc_next    = idle_digit ? digit_val : '0;
                end
            end
            M_STRING:
            begin
                emit = 1'b1;
                if (ch == CH_QUOTE)
                begin
                    ent.t0.kind = KIND_STRING_END;
                    mode_next   = M_IDLE;
                end
                else if (ch == CH_NUL)
                begin
                    ent.t0.kind = KIND_OPEN_STRING;
                    ent.two     = 1'b1;
                    ent.t1.kind = KIND_EOF;
                    mode_next   = M_IDLE;
                    acc_next    = '0;
                end
                else
                begin
                    ent.t0 = '{kind: KIND_TEXT, chr: ch};
                end
            end
            default:
            begin
                emit      = idle_emit;
                ent.t0    = '{kind: idle_kind, chr: idle_chr};
                mode_next = idle_mode;
                acc_next  = idle_digit ? digit_val : '0;
            end
        endcase
    end

    assign ch_ready = !q_full;
    assign accept   = ch_valid && ch_ready;
    assign q_push   = accept && emit;
    assign q_entry  = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

@@ design/at_queue.sv @@
// ----------------------------------------------------------------------------
// at_queue
// Short token queue decoupling the lexer front end from the output stage.
// ----------------------------------------------------------------------------
module at_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  at_pkg::entry_t  push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output at_pkg::entry_t  head_entry
);
    import at_pkg::*;

    entry_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ design/at_back.sv @@
// ----------------------------------------------------------------------------
// at_back
// Output stage: splits queued entries into single tokens on a registered port.
// ----------------------------------------------------------------------------
module at_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  at_pkg::entry_t            head_entry,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [at_pkg::KIND_W-1:0] out_kind,
    output logic [at_pkg::CHR_W-1:0]  out_chr,
    output logic [at_pkg::VAL_W-1:0]  out_value,
    output logic                      out_last,
    output logic                      pend
);
    import at_pkg::*;

    logic             valid_reg;
    tok_t             tok_reg;
    logic [VAL_W-1:0] value_reg;
    logic             last_reg;
    logic             pend_reg;
    tok_t             pend_tok_reg;
    logic             load;

    // output register free or being taken this cycle
    assign load = !valid_reg || out_ready;
    assign pop  = load && !pend_reg && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= head_valid;
                pend_reg  <= head_valid && head_entry.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                tok_reg   <= pend_tok_reg;
                value_reg <= '0;
                last_reg  <= 1'b1;
            end
            else
            begin
                tok_reg      <= head_entry.t0;
                value_reg    <= head_entry.value;
                last_reg     <= !head_entry.two;
                pend_tok_reg <= head_entry.t1;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = tok_reg.kind;
    assign out_chr   = tok_reg.chr;
    assign out_value = value_reg;
    assign out_last  = last_reg;
    assign pend      = pend_reg;

endmodule

@@ test/assembly_tokenizer_check.sv @@
// ----------------------------------------------------------------------------
// assembly_tokenizer_check
// Watches both streams of the tokenizer, predicts the tokens that each
// accepted character causes and compares every output item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module assembly_tokenizer_check #(
    parameter int INT_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    import at_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_COMMENT,
        LX_NUMBER,
        LX_WORD,
        LX_LABEL,
        LX_STRING
    } lex_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHR_W-1:0]  chr;
        logic [VAL_W-1:0]  value;
        logic              last;
    } lex_token_t;

    localparam logic [63:0] ACCUM_MAX = (64'd1 << INT_BITS) - 64'd1;

    lex_mode_t   lex_mode;
    logic [63:0] num_accum;
    lex_token_t  awaited_tokens[$];
    lex_token_t  step_tok[2];
    int          step_cnt;
    int          tokens_seen;

    initial begin
        errors      = 0;
        pending     = 0;
        tokens_seen = 0;
    end

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == "!" || c == "?" || c == "-";
    endfunction

    function automatic void emit(input logic [KIND_W-1:0] kind, input logic [CHR_W-1:0] chr,
                                 input logic [63:0] value);
        if (step_cnt < 2) begin
            step_tok[step_cnt].kind  = kind;
            step_tok[step_cnt].chr   = chr;
            step_tok[step_cnt].value = value[VAL_W-1:0];
            step_tok[step_cnt].last  = 1'b0;
            step_cnt++;
        end
    endfunction

    function automatic void lex_from_idle(input logic [7:0] c);
        lex_mode = LX_IDLE;
        case (c)
            " ", "\t", "\n", "\r": ;
            ";":   lex_mode = LX_COMMENT;
            8'h00:
            begin
                emit(KIND_EOF, 0, 0);
                num_accum = 0;
            end
            "{":   emit(KIND_LBRACE, 0, 0);
            "}":   emit(KIND_RBRACE, 0, 0);
            "(":   emit(KIND_LPAREN, 0, 0);
            ")":   emit(KIND_RPAREN, 0, 0);
            "\"":  lex_mode = LX_STRING;
            "%":   lex_mode = LX_LABEL;
            default:
            begin
                if (is_num(c))
                begin
                    lex_mode  = LX_NUMBER;
                    num_accum = c - "0";
                end
                else if (is_word(c))
                begin
                    lex_mode = LX_WORD;
                    emit(KIND_TEXT, c, 0);
                end
                else
                    emit(KIND_ILLEGAL, c, 0);
            end
        endcase
    endfunction

    // tokens caused by one accepted character, appended in order
    function automatic void lex_char(input logic [7:0] c);
        logic [63:0] d;
        int          i;
        step_cnt = 0;
        d        = 0;
        case (lex_mode)
            LX_COMMENT:
            begin
                if (c == "\n")
                    lex_mode = LX_IDLE;
                else if (c == 8'h00)
                begin
                    lex_mode = LX_IDLE;
                    emit(KIND_EOF, 0, 0);
                    num_accum = 0;
                end
            end
            LX_NUMBER:
            begin
                if (is_num(c))
                begin
                    d = c - "0";
                    if (num_accum > (ACCUM_MAX - d) / 10)
                        num_accum = ACCUM_MAX;
                    else
                        num_accum = num_accum * 10 + d;
                end
                else
                begin
                    emit(KIND_INTEGER, 0, num_accum);
                    num_accum = 0;
                    lex_from_idle(c);
                end
            end
            LX_WORD, LX_LABEL:
            begin
                if (is_word(c))
                    emit(KIND_TEXT, c, 0);
                else
                begin
                    emit(lex_mode == LX_WORD ? KIND_IDENT_END : KIND_LABEL_END, 0, 0);
                    lex_from_idle(c);
                end
            end
            LX_STRING:
            begin
                if (c == "\"")
                begin
                    emit(KIND_STRING_END, 0, 0);
                    lex_mode = LX_IDLE;
                end
                else if (c == 8'h00)
                begin
                    emit(KIND_OPEN_STRING, 0, 0);
                    emit(KIND_EOF, 0, 0);
                    lex_mode  = LX_IDLE;
                    num_accum = 0;
                end
                else
                    emit(KIND_TEXT, c, 0);
            end
            default: lex_from_idle(c);
        endcase
        if (step_cnt > 0)
            step_tok[step_cnt-1].last = 1'b1;
        for (i = 0; i < step_cnt; i++)
            awaited_tokens.push_back(step_tok[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: token %0d: %s: got %0d, expected %0d",
                 $realtime, tokens_seen, what, got, want);
        errors++;
    endtask

    task automatic check_token();
        lex_token_t want;
        if (awaited_tokens.size() == 0)
        begin
            report_mismatch("token with none awaited, kind", m_tuser, 0);
            return;
        end
        want = awaited_tokens.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch("kind", m_tuser, want.kind);
        if (m_tdata[CHR_W-1:0] !== want.chr)
            report_mismatch("text_char", m_tdata[CHR_W-1:0], want.chr);
        if (m_tdata[CHR_W +: VAL_W] !== want.value)
            report_mismatch("int_value", m_tdata[CHR_W +: VAL_W], want.value);
        if (m_tlast !== want.last)
            report_mismatch("last_of_run", m_tlast, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode  = LX_IDLE;
            num_accum = 0;
            awaited_tokens.delete();
            pending <= 0;
        end
        else
        begin
            // input first, so that a token caused in the same cycle could still match
            if (s_tvalid && s_tready)
                lex_char(s_tdata);
            if (m_tvalid && m_tready)
            begin
                check_token();
                tokens_seen++;
            end
            pending <= awaited_tokens.size();
        end
    end

endmodule

@@ test/assembly_tokenizer_test.sv @@
// ----------------------------------------------------------------------------
// assembly_tokenizer_test
// Feeds the tokenizer a directed character sequence and then random lexemes
// (identifiers, labels, integers, strings, comments, noise) with random gaps
// and output stalls; a checker beside the block predicts and compares tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module assembly_tokenizer_test;

    localparam int HOLD_CYCLES = 150;
    localparam int IDLE_LIMIT  = 1000;
    localparam int N_CHARS     = 1000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int errors;
    int pending;
    int chars_sent;
    int idle_cycles;
    bit tx_calm;
    bit rx_calm;
    bit rx_hold_req;

    assembly_tokenizer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assembly_tokenizer_check token_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int draw_gap(input bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 19);
    endfunction

    task automatic send_char(input logic [7:0] c);
        int w;
        w = draw_gap(tx_calm);
        if (w > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // stop offering and wait until every awaited token has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] word_char();
        int n;
        n = $urandom_range(0, 54);
        if (n < 26)
            return "a" + n;
        if (n < 52)
            return "A" + n - 26;
        if (n == 52)
            return "!";
        if (n == 53)
            return "?";
        return "-";
    endfunction

    function automatic logic [7:0] digit_char();
        return "0" + $urandom_range(0, 9);
    endfunction

    // any byte except a quote and the end of input
    function automatic logic [7:0] string_char();
        logic [7:0] c;
        do c = $urandom_range(1, 255); while (c == "\"");
        return c;
    endfunction

    task automatic send_number();
        int sel;
        int n;
        int i;
        sel = $urandom_range(0, 9);
        if (sel == 9)
        begin
            // straddles the saturation point
            send_text("21474836");
            send_char(digit_char());
            send_char(digit_char());
        end
        else
        begin
            n = (sel < 7) ? $urandom_range(1, 4) : $urandom_range(10, 14);
            for (i = 0; i < n; i++)
                send_char(digit_char());
        end
    endtask

    task automatic send_lexeme();
        int         pick;
        int         n;
        int         i;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                send_char(word_char());
        end
        else if (pick < 28)
        begin
            send_char("%");
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                send_char(word_char());
        end
        else if (pick < 43)
            send_number();
        else if (pick < 55)
        begin
            send_char("\"");
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++)
                send_char(string_char());
            send_char($urandom_range(0, 9) == 0 ? 8'h00 : "\"");
        end
        else if (pick < 67)
        begin
            case ($urandom_range(0, 3))
                0:       send_char("{");
                1:       send_char("}");
                2:       send_char("(");
                default: send_char(")");
            endcase
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 3))
                0:       send_char(" ");
                1:       send_char("\t");
                2:       send_char("\n");
                default: send_char("\r");
            endcase
        end
        else if (pick < 87)
        begin
            send_char(";");
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++)
            begin
                do c = $urandom_range(1, 255); while (c == "\n");
                send_char(c);
            end
            send_char($urandom_range(0, 7) == 0 ? 8'h00 : "\n");
        end
        else if (pick < 97)
            send_char($urandom_range(0, 255));
        else
            send_char(8'h00);
    endtask

    initial
    begin : receiver
        int w;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            w = draw_gap(rx_calm);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("assembly_tokenizer_test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        chars_sent  = 0;
        idle_cycles = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        rx_hold_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // punctuation, identifier ended by a paren, empty label, integer ended
        // by a high byte, string with a high byte, comment, blanks, end of
        // input in idle, in an open string and in a comment
        send_text("{}()Z?)%{42");
        send_char(8'hFF);
        send_text("\"A");
        send_char(8'h80);
        send_text("\";x\n\t");
        send_char(8'h00);
        send_char("\"");
        send_char(8'h00);
        send_char(";");
        send_char(8'h00);

        while (chars_sent < 350)
            send_lexeme();

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        while (chars_sent < 550)
            send_lexeme();

        // output held off while characters keep coming
        rx_calm     = 1'b0;
        rx_hold_req = 1'b1;
        while (chars_sent < 580)
            send_lexeme();
        tx_calm = 1'b0;
        drain();

        while (chars_sent < N_CHARS)
            send_lexeme();
        send_char(8'h00);
        drain();
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("assembly_tokenizer_test passed");
        else
            $display("assembly_tokenizer_test failed");
        $finish;
    end

endmodule
